>>> hw/rtl/mtde_pkg.sv
// Shared types and constants of the motion trace delta encoder.
`default_nettype none
package mtde_pkg;

   localparam int SAMPLE_PERIOD   = 8;
   localparam int KEYFRAME_PERIOD = 32;
   localparam int PHASE_W  = (SAMPLE_PERIOD > 1) ? $clog2(SAMPLE_PERIOD) : 1;
   localparam int SAMPLE_W = (KEYFRAME_PERIOD > 1) ? $clog2(KEYFRAME_PERIOD) : 1;

   localparam int MAX_BYTES = 16;
   localparam int IDX_W     = $clog2(MAX_BYTES);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0]  CMD_KEYFRAME = 8'h80;
   localparam logic [7:0]  CMD_ANIM     = 8'h81;
   localparam logic [7:0]  CMD_SPLIT    = 8'h83;
   localparam logic [7:0]  CMD_STILL    = 8'h84;
   localparam logic signed [15:0] DELTA_HI = 16'sh0080;
   localparam logic signed [15:0] DELTA_LO = -16'sh007c;
   localparam logic [31:0] DT_LIMIT     = 32'h0000_ff01;
   localparam logic [16:0] HEADROOM     = 17'h00040;
   localparam logic [15:0] CAP_RESET    = 16'h4000;

   typedef enum logic {
      KIND_DATA = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   typedef struct packed {
      logic        race_done;
      logic        hold;
      logic        end_menu;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [7:0]  anim_frame;
      logic [7:0]  anim_index;
      logic        split_flag;
      logic [15:0] rot_y;
      logic [15:0] rot_z;
      logic [15:0] elapsed_ms;
   } frame_type;

   typedef struct packed {
      kind_type                   kind;
      logic                       overflow;
      logic [IDX_W-1:0]           len_m1;
      logic [MAX_BYTES-1:0][7:0]  bytes;
   } job_type;

endpackage
`default_nettype wire

>>> hw/rtl/mtde_front.sv
// Front end: frame gating, delta classification, state update and chunk assembly.
`default_nettype none
module mtde_front (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_valid,
   input  wire  [15:0]        csr_data,
   input  wire                frame_valid,
   output logic               frame_ready,
   input  mtde_pkg::frame_type frame,
   input  wire                q_full,
   output logic               push,
   output mtde_pkg::job_type  push_job
);

   logic [15:0] capacity_ff, capacity_in;
   logic [15:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in, prev_z_ff, prev_z_in;
   logic [7:0]  anim_frame_ff, anim_frame_in, anim_index_ff, anim_index_in;
   logic        split_ff, split_in;
   logic [mtde_pkg::PHASE_W-1:0]  phase_ff, phase_in;
   logic [mtde_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic [31:0] race_time_ff, race_time_in, key_time_ff, key_time_in;
   logic [15:0] written_ff, written_in;
   logic        rec_ff, rec_in;

   logic [15:0] cx, cy, cz;
   logic signed [15:0] dx, dy, dz;
   logic [31:0] dt;
   logic        dt_ok, small_ok, compact, still, anim_chg, split_chg, accept;
   logic [7:0]  rby, rbz;
   logic [4:0][7:0]  head;
   logic [10:0][7:0] motion;
   logic [2:0]  hc;
   logic [3:0]  mc;
   logic [4:0]  total_n, mi;
   logic [16:0] sum, bw_head;
   logic        too_full;

   assign frame_ready = !q_full;
   assign accept      = frame_valid && !q_full;

   always_comb begin
      cx = frame.pos_x[18:3];
      cy = frame.pos_y[18:3];
      cz = frame.pos_z[18:3];
      dx = cx - prev_x_ff;
      dy = cy - prev_y_ff;
      dz = cz - prev_z_ff;
      dt = race_time_ff - key_time_ff;
      dt_ok = dt[31] || (dt < mtde_pkg::DT_LIMIT);
      small_ok = (dx < mtde_pkg::DELTA_HI) && (dx > mtde_pkg::DELTA_LO)
              && (dy < mtde_pkg::DELTA_HI) && (dy > mtde_pkg::DELTA_LO)
              && (dz < mtde_pkg::DELTA_HI) && (dz > mtde_pkg::DELTA_LO);
      compact = !frame.race_done && (sample_ff != '0) && small_ok && dt_ok;
      still = (dx == '0) && (dy == '0) && (dz == '0);
      rby = frame.rot_y[11:4];
      rbz = frame.rot_z[11:4];
      anim_chg = (frame.anim_frame != anim_frame_ff) || (frame.anim_index != anim_index_ff);
      split_chg = frame.split_flag != split_ff;

      head = '0;
      if (anim_chg) begin
         head[0] = mtde_pkg::CMD_ANIM;
         head[1] = frame.anim_index;
         head[2] = frame.anim_frame;
         head[3] = mtde_pkg::CMD_SPLIT;
         head[4] = {7'd0, frame.split_flag};
      end else begin
         head[0] = mtde_pkg::CMD_SPLIT;
         head[1] = {7'd0, frame.split_flag};
      end
      hc = (anim_chg ? 3'd3 : 3'd0) + (split_chg ? 3'd2 : 3'd0);

      motion = '0;
      if (compact && still) begin
         motion[0] = mtde_pkg::CMD_STILL;
         mc = 4'd1;
      end else if (compact) begin
         motion[0] = dx[7:0];
         motion[1] = dy[7:0];
         motion[2] = dz[7:0];
         motion[3] = rby;
         motion[4] = rbz;
         mc = 4'd5;
      end else begin
         motion[0]  = mtde_pkg::CMD_KEYFRAME;
         motion[1]  = cx[15:8];
         motion[2]  = cx[7:0];
         motion[3]  = cy[15:8];
         motion[4]  = cy[7:0];
         motion[5]  = cz[15:8];
         motion[6]  = cz[7:0];
         motion[7]  = dt[15:8];
         motion[8]  = dt[7:0];
         motion[9]  = rby;
         motion[10] = rbz;
         mc = 4'd11;
      end
      total_n = {2'd0, hc} + {1'b0, mc};

      push_job.kind     = mtde_pkg::KIND_DATA;
      push_job.len_m1   = 4'(total_n - 5'd1);
      for (int i = 0; i < mtde_pkg::MAX_BYTES; i++) begin
         mi = 5'(i) - {2'd0, hc};
         if (5'(i) < {2'd0, hc}) begin
            push_job.bytes[i] = head[3'(i)];
         end else if (mi < 5'd11) begin
            push_job.bytes[i] = motion[mi[3:0]];
         end else begin
            push_job.bytes[i] = '0;
         end
      end

      sum = {1'b0, written_ff} + {12'd0, total_n};
      written_in = sum[16] ? 16'hffff : sum[15:0];
      bw_head = {1'b0, written_in} + mtde_pkg::HEADROOM;
      too_full = {1'b0, capacity_ff} < bw_head;
      push_job.overflow = too_full && !frame.end_menu;

      capacity_in   = csr_valid ? csr_data : capacity_ff;
      prev_x_in     = cx;
      prev_y_in     = cy;
      prev_z_in     = cz;
      anim_frame_in = frame.anim_frame;
      anim_index_in = frame.anim_index;
      split_in      = frame.split_flag;
      phase_in  = (phase_ff == mtde_pkg::PHASE_W'(mtde_pkg::SAMPLE_PERIOD - 1))
                ? '0 : phase_ff + 1'b1;
      sample_in = (sample_ff == mtde_pkg::SAMPLE_W'(mtde_pkg::KEYFRAME_PERIOD - 1))
                ? '0 : sample_ff + 1'b1;
      race_time_in  = race_time_ff + {16'd0, frame.elapsed_ms};
      key_time_in   = compact ? key_time_ff : race_time_ff;
      rec_in        = too_full ? 1'b0 : rec_ff;

      push = 1'b0;
      if (accept) begin
         priority if (!frame.race_done && (!rec_ff || frame.hold)) begin
            push = 1'b0;
         end else if (!frame.race_done && frame.end_menu) begin
            push = 1'b1;
            push_job.kind     = mtde_pkg::KIND_END;
            push_job.overflow = 1'b0;
            push_job.len_m1   = '0;
            push_job.bytes    = '0;
         end else begin
            push = frame.race_done || (phase_ff == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= mtde_pkg::CAP_RESET;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_z_ff     <= '0;
         anim_frame_ff <= '0;
         anim_index_ff <= '0;
         split_ff      <= 1'b0;
         phase_ff      <= '0;
         sample_ff     <= '0;
         race_time_ff  <= '0;
         key_time_ff   <= '0;
         written_ff    <= '0;
         rec_ff        <= 1'b1;
      end else begin
         capacity_ff <= capacity_in;
         if (accept && (frame.race_done || (rec_ff && !frame.hold && !frame.end_menu))) begin
            phase_ff     <= phase_in;
            race_time_ff <= race_time_in;
            if (push) begin
               prev_x_ff     <= prev_x_in;
               prev_y_ff     <= prev_y_in;
               prev_z_ff     <= prev_z_in;
               anim_frame_ff <= anim_frame_in;
               anim_index_ff <= anim_index_in;
               split_ff      <= split_in;
               sample_ff     <= sample_in;
               key_time_ff   <= key_time_in;
               written_ff    <= written_in;
               rec_ff        <= rec_in;
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/mtde_queue.sv
// Two-entry job queue between the front end and the byte serializer.
`default_nettype none
module mtde_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  mtde_pkg::job_type push_job,
   output logic              full,
   input  wire               pop,
   output logic              head_valid,
   output mtde_pkg::job_type head_job
);

   localparam int PTR_W = $clog2(mtde_pkg::QUEUE_DEPTH);

   mtde_pkg::job_type store_ff [mtde_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   count_ff, count_in;

   always_comb begin
      full       = count_ff == (PTR_W+1)'(mtde_pkg::QUEUE_DEPTH);
      head_valid = count_ff != '0;
      head_job   = store_ff[rd_ff];
      wr_in      = push ? wr_ff + 1'b1 : wr_ff;
      rd_in      = pop ? rd_ff + 1'b1 : rd_ff;
      count_in   = count_ff + {{PTR_W{1'b0}}, push} - {{PTR_W{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/mtde_back.sv
// Back end: serializes queued jobs into registered output bytes.
`default_nettype none
module mtde_back (
   input  wire               clock,
   input  wire               reset,
   input  wire               head_valid,
   input  mtde_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic [7:0]        rsp_byte,
   output logic              rsp_last,
   output logic              rsp_kind,
   output logic              rsp_overflow
);

   logic                       valid_ff, valid_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       last_ff, last_in, kind_ff, kind_in, ovf_ff, ovf_in;
   logic [mtde_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                       load, at_end;

   always_comb begin
      load     = !valid_ff || rsp_ready;
      at_end   = idx_ff == head_job.len_m1;
      pop      = load && head_valid && at_end;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      kind_in  = kind_ff;
      ovf_in   = ovf_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = head_valid;
         byte_in  = head_job.bytes[idx_ff];
         last_in  = at_end;
         kind_in  = head_job.kind;
         ovf_in   = head_job.overflow && at_end;
         if (head_valid) begin
            idx_in = at_end ? '0 : idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      kind_ff <= kind_in;
      ovf_ff  <= ovf_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_byte     = byte_ff;
   assign rsp_last     = last_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_overflow = ovf_ff;

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff |-> last_ff && !ovf_ff)
      else $error("end request without last");

   a_ovf_on_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && ovf_ff |-> last_ff)
      else $error("overflow flag off the last byte");

   a_pop_rewinds: assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == '0)
      else $error("byte index not rewound after job");

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> idx_ff <= head_job.len_m1)
      else $error("byte index beyond job length");

endmodule
`default_nettype wire

>>> hw/rtl/motion_trace_delta_encoder.sv
// Top level of the motion trace delta encoder.
// One frame transfer is accepted per clock while the two-entry job queue has room;
// every frame is classified, and any state update registered, in the cycle it is accepted.
// Results leave one byte per clock, while rsp_tready allows, from a registered serializer,
// so a sampled frame yields 1 to 16 bytes (the byte count of its chunks) and the
// serializer sets the sustained rate; the first byte passes the job queue register and
// then the serializer's output register. Writes to buffer_capacity are always accepted.
`default_nettype none
module motion_trace_delta_encoder (
   input  wire          clock,
   input  wire          reset,
   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [15:0]  csr_data,      // buffer_capacity
   input  wire          req_tvalid,
   output logic         req_tready,
   // race_done, hold, end_menu, pos_x, pos_y, pos_z, anim_frame, anim_index,
   // split_flag, rot_y, rot_z, elapsed_ms, zero fill
   input  wire  [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [7:0]   rsp_tdata,     // data_byte
   output logic         rsp_tlast,
   output logic [1:0]   rsp_tuser      // kind, overflow
);

   mtde_pkg::frame_type frame;
   mtde_pkg::job_type   push_job, head_job;
   logic push, q_full, pop, head_valid, rsp_kind, rsp_overflow;

   assign csr_ready = 1'b1;

   always_comb begin
      frame.race_done  = req_tdata[0];
      frame.hold       = req_tdata[1];
      frame.end_menu   = req_tdata[2];
      frame.pos_x      = req_tdata[34:3];
      frame.pos_y      = req_tdata[66:35];
      frame.pos_z      = req_tdata[98:67];
      frame.anim_frame = req_tdata[106:99];
      frame.anim_index = req_tdata[114:107];
      frame.split_flag = req_tdata[115];
      frame.rot_y      = req_tdata[131:116];
      frame.rot_z      = req_tdata[147:132];
      frame.elapsed_ms = req_tdata[163:148];
   end

   mtde_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .frame_valid (req_tvalid),
      .frame_ready (req_tready),
      .frame       (frame),
      .q_full      (q_full),
      .push        (push),
      .push_job    (push_job)
   );

   mtde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   mtde_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_byte     (rsp_tdata),
      .rsp_last     (rsp_tlast),
      .rsp_kind     (rsp_kind),
      .rsp_overflow (rsp_overflow)
   );

   assign rsp_tuser = {rsp_overflow, rsp_kind};

endmodule
`default_nettype wire
